// ===== hdl/fragment_set_validator_assert.svh =====
// assertion macros for the fragment set validator
// used by modules that carry concurrent checks on clk_i / rst_ni
`ifndef FRAGMENT_SET_VALIDATOR_ASSERT_SVH
`define FRAGMENT_SET_VALIDATOR_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define FSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// condition must never be true at a clock edge out of reset
`define FSV_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define FSV_ASSERT(lbl, prop, msg)
`define FSV_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hdl/fsv_pkg.sv =====
// shared types and constants of the fragment set validator
// no dependencies
package fsv_pkg;

  localparam int unsigned MaxFragmentsDefault = 16;
  localparam int unsigned IdW   = 4;
  localparam int unsigned IdSpan = 2 ** IdW;
  localparam int unsigned CntW  = 2;
  localparam int unsigned RecvW = 5;
  localparam int unsigned LenW  = 12;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_FRAG_ERR = 3'd2,
    ST_HEADER   = 3'd3,
    ST_BAD_ID   = 3'd4,
    ST_MISSING  = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KNOWN_A = 1'b0,
    CFG_KNOWN_B = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_EMIT
  } seq_state_e;

  typedef struct packed {
    logic in_fire;
    logic last;
    logic scan_end;
    logic out_free;
  } seq_stat_t;

  typedef struct packed {
    logic in_ready;
    logic update;
    logic scan;
    logic emit;
  } seq_ctrl_t;

endpackage

// ===== hdl/fsv_in_if.sv =====
// fragment header channel: valid/ready handshake plus header fields
// depends on fsv_pkg
interface fsv_in_if;
  logic                     valid;
  logic                     ready;
  logic [7:0]               station;
  logic [7:0]               command_code;
  logic [fsv_pkg::IdW-1:0]  fragment_total;
  logic [fsv_pkg::IdW-1:0]  fragment_id;
  logic                     fragment_bad;
  logic [7:0]               frag_bytes;
  logic                     last_fragment;

  modport source (
    output valid, station, command_code, fragment_total, fragment_id,
           fragment_bad, frag_bytes, last_fragment,
    input  ready
  );
  modport sink (
    input  valid, station, command_code, fragment_total, fragment_id,
           fragment_bad, frag_bytes, last_fragment,
    output ready
  );
endinterface

// ===== hdl/fsv_out_if.sv =====
// verdict channel: valid/ready handshake plus status, length and code
// depends on fsv_pkg
interface fsv_out_if;
  logic                     valid;
  logic                     ready;
  fsv_pkg::status_e         status;
  logic [fsv_pkg::LenW-1:0] set_bytes;
  logic [7:0]               command_code_out;

  modport source (
    output valid, status, set_bytes, command_code_out,
    input  ready
  );
  modport sink (
    input  valid, status, set_bytes, command_code_out,
    output ready
  );
endinterface

// ===== hdl/fsv_seen_table.sv =====
// bank of 2-bit saturating per-fragment-number counters, one shared port
// depends on fsv_pkg
module fsv_seen_table #(
  parameter int unsigned DEPTH = fsv_pkg::IdSpan
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  logic                             inc_i,
  input  logic [$clog2(DEPTH)-1:0]         addr_i,
  output logic [fsv_pkg::CntW-1:0]         cnt_o
);
  import fsv_pkg::*;

  logic [CntW-1:0] cnt_q [DEPTH];

  assign cnt_o = cnt_q[addr_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) cnt_q[i] <= '0;
    end else if (clear_i) begin
      for (int i = 0; i < DEPTH; i++) cnt_q[i] <= '0;
    end else if (inc_i && (cnt_q[addr_i] != {CntW{1'b1}})) begin
      cnt_q[addr_i] <= cnt_q[addr_i] + CntW'(1);
    end
  end
endmodule

// ===== hdl/fsv_seq.sv =====
// sequencer: accept, update, counter scan, emit
// depends on fsv_pkg
module fsv_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsv_pkg::seq_stat_t  stat_i,
  output fsv_pkg::seq_ctrl_t  ctrl_o
);
  import fsv_pkg::*;

  seq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (stat_i.in_fire) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        ctrl_o.update = 1'b1;
        state_d = stat_i.last ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.scan_end) state_d = S_EMIT;
      end
      S_EMIT: begin
        ctrl_o.emit = 1'b1;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ===== hdl/fragment_set_validator.sv =====
// top level of the fragment set validator: header checks, length sum,
// verdict register; uses fsv_pkg, fsv_in_if, fsv_out_if, fsv_seq, fsv_seen_table
//
// Checks the headers of the fragments of one multi-fragment command and
// gives one verdict (status, total payload length, first command code) when
// the fragment marked last arrives. A fragment that is not last passes the
// accept and update states. A last fragment passes the accept and update
// states, then the scan state, which reads fragment numbers 1 up to the
// fragments received plus an end check, stopping early at the first missing
// number, then the emit state, which loads the verdict register; the scan
// length is set by the single read port of the counter bank, which reads one
// counter per cycle. The next fragment is taken while a verdict still waits
// in the output register; a further verdict waits until that register is
// free. The user must write known_code_a and known_code_b through the
// configuration port only while the block is idle, which it does not enforce.
`include "fragment_set_validator_assert.svh"

module fragment_set_validator #(
  parameter int unsigned MAX_FRAGMENTS = fsv_pkg::MaxFragmentsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fsv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fsv_pkg::CfgDataW-1:0]  cfg_wdata_i,
  fsv_in_if.sink                        in_i,
  fsv_out_if.source                     out_o
);
  import fsv_pkg::*;

  // fragment numbers are only IdW bits wide, so entries beyond IdSpan never fill
  localparam int unsigned TableDepth = (MAX_FRAGMENTS < IdSpan) ? MAX_FRAGMENTS : IdSpan;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned ScanW = RecvW + 1;

  seq_ctrl_t ctrl;
  seq_stat_t stat;

  // configuration
  logic [7:0] known_a_q, known_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_a_q <= 8'd0;
      known_b_q <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_KNOWN_A: known_a_q <= cfg_wdata_i;
        CFG_KNOWN_B: known_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // captured fragment header
  logic [7:0]     station_q, code_q, plen_q;
  logic [IdW-1:0] total_q, id_q;
  logic           bad_q, last_q;
  logic           in_fire;

  assign in_i.ready = ctrl.in_ready;
  assign in_fire    = in_i.valid && ctrl.in_ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      station_q <= in_i.station;
      code_q    <= in_i.command_code;
      total_q   <= in_i.fragment_total;
      id_q      <= in_i.fragment_id;
      bad_q     <= in_i.fragment_bad;
      plen_q    <= in_i.frag_bytes;
      last_q    <= in_i.last_fragment;
    end
  end

  // set state
  logic [7:0]       first_station_q, first_code_q;
  logic [IdW-1:0]   first_total_q;
  logic [2:0]       frag_err_q;
  logic [RecvW-1:0] recv_q;
  logic [LenW-1:0]  len_q;
  logic [ScanW-1:0] scan_n_q;
  logic             missing_q, dup_q;

  // out register
  logic             out_valid_q;
  status_e          out_status_q;
  logic [LenW-1:0]  out_len_q;
  logic [7:0]       out_code_q;
  logic             out_free, emit_fire;

  assign out_free  = !out_valid_q || out_o.ready;
  assign emit_fire = ctrl.emit && out_free;

  // shared counter port: update reads the fragment's own number, scan walks numbers
  logic [IdxW-1:0] tbl_addr;
  logic [CntW-1:0] tbl_cnt;
  logic            id_in_range, n_in_range, n_past_end, tbl_inc;
  logic [CntW-1:0] scan_cnt;

  assign id_in_range = {1'b0, id_q} < (IdW+1)'(TableDepth);
  assign n_in_range  = scan_n_q < ScanW'(TableDepth);
  assign n_past_end  = scan_n_q > {1'b0, recv_q};
  assign tbl_addr    = ctrl.scan ? scan_n_q[IdxW-1:0] : id_q[IdxW-1:0];
  assign tbl_inc     = ctrl.update && id_in_range;
  assign scan_cnt    = n_in_range ? tbl_cnt : '0;

  fsv_seen_table #(
    .DEPTH (TableDepth)
  ) u_seen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (emit_fire),
    .inc_i   (tbl_inc),
    .addr_i  (tbl_addr),
    .cnt_o   (tbl_cnt)
  );

  assign stat.in_fire  = in_fire;
  assign stat.last     = last_q;
  assign stat.scan_end = n_past_end || (scan_cnt == '0);
  assign stat.out_free = out_free;

  fsv_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // per-fragment checks against the first fragment's header
  logic           first_frag;
  logic [7:0]     ref_station, ref_code;
  logic [IdW-1:0] ref_total;
  logic [2:0]     code_here;
  logic [LenW:0]  len_sum;

  assign first_frag  = (recv_q == '0);
  assign ref_station = first_frag ? station_q : first_station_q;
  assign ref_code    = first_frag ? code_q    : first_code_q;
  assign ref_total   = first_frag ? total_q   : first_total_q;
  assign len_sum     = {1'b0, len_q} + (LenW+1)'(plen_q);

  always_comb begin
    code_here = 3'(ST_OK);
    if (bad_q) code_here = 3'(ST_FRAG_ERR);
    if (station_q != ref_station || total_q != ref_total || code_q != ref_code) begin
      code_here = 3'(ST_HEADER);
    end
    if (id_q > ref_total) code_here = 3'(ST_BAD_ID);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_station_q <= '0;
      first_code_q    <= '0;
      first_total_q   <= '0;
      frag_err_q      <= '0;
      recv_q          <= '0;
      len_q           <= '0;
      scan_n_q        <= '0;
      missing_q       <= 1'b0;
      dup_q           <= 1'b0;
    end else if (emit_fire) begin
      first_station_q <= '0;
      first_code_q    <= '0;
      first_total_q   <= '0;
      frag_err_q      <= '0;
      recv_q          <= '0;
      len_q           <= '0;
      missing_q       <= 1'b0;
      dup_q           <= 1'b0;
    end else if (ctrl.update) begin
      first_station_q <= ref_station;
      first_code_q    <= ref_code;
      first_total_q   <= ref_total;
      if (code_here != 3'(ST_OK)) frag_err_q <= code_here;
      if (recv_q != {RecvW{1'b1}}) recv_q <= recv_q + RecvW'(1);
      len_q     <= len_sum[LenW] ? {LenW{1'b1}} : len_sum[LenW-1:0];
      scan_n_q  <= ScanW'(1);
      missing_q <= 1'b0;
      dup_q     <= 1'b0;
    end else if (ctrl.scan && !n_past_end) begin
      if (scan_cnt == '0) missing_q <= 1'b1;
      if (scan_cnt > CntW'(1)) dup_q <= 1'b1;
      scan_n_q <= scan_n_q + ScanW'(1);
    end
  end

  // verdict priority: missing, duplicate, kept fragment code, unknown command
  status_e verdict;

  always_comb begin
    if (missing_q) begin
      verdict = ST_MISSING;
    end else if (dup_q) begin
      verdict = ST_BAD_ID;
    end else if (frag_err_q != 3'(ST_OK)) begin
      verdict = status_e'(frag_err_q);
    end else if (first_code_q != known_a_q && first_code_q != known_b_q) begin
      verdict = ST_UNKNOWN;
    end else begin
      verdict = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_status_q <= verdict;
      out_len_q    <= len_q;
      out_code_q   <= first_code_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_status_q;
  assign out_o.set_bytes        = out_len_q;
  assign out_o.command_code_out = out_code_q;

  // an accepted transaction is always followed by its update cycle
  `FSV_ASSERT(a_fire_then_update, in_fire |=> ctrl.update, "no update after accept")
  // scan index never runs more than one past the received count
  `FSV_ASSERT(a_scan_bound, ctrl.scan |-> (scan_n_q <= {1'b0, recv_q} + ScanW'(1)), "scan past end")
  // a delivered verdict leaves an empty set behind
  `FSV_ASSERT(a_set_cleared, emit_fire |=> (recv_q == '0 && len_q == '0 && out_valid_q), "set not cleared")
  // counters are never bumped while scanning
  `FSV_ASSERT_NEVER(a_no_inc_in_scan, tbl_inc && ctrl.scan, "counter bumped during scan")
endmodule
